// File: hdl/bdeg_pkg.sv
// ----------------------------------------------------------------------------
// bdeg_pkg
// Types and constants shared by the button debounce and event generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bdeg_pkg;

   localparam int TIME_W   = 32;
   localparam int CFG_W    = 16;
   localparam int COUNT_W  = 8;
   localparam int EVENT_W  = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_CHANGED  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_PRESSED  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LONG     = 3'd4;
   localparam logic [EVENT_W-1:0] EV_BURST    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_HIGH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MS         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_MS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_DELAY_MS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_INTERVAL_MS = 3'd6;

   localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET       = 16'd50;
   localparam logic [CFG_W-1:0] REPEAT_MS_RESET         = 16'd500;
   localparam logic [CFG_W-1:0] LONG_PRESS_MS_RESET     = 16'd1000;
   localparam logic [CFG_W-1:0] BURST_DELAY_MS_RESET    = 16'd1500;
   localparam logic [CFG_W-1:0] BURST_INTERVAL_MS_RESET = 16'd200;
   localparam logic [CFG_W-1:0] MIN_INTERVAL            = 16'h0001;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 8'h01;

   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_code;
      logic [COUNT_W-1:0] click_count;
      logic [TIME_W-1:0]  hold_length;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic debounce;
      logic window;
      logic div_step;
      logic burst;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      logic burst_check;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/bdeg_ctrl.sv
// ----------------------------------------------------------------------------
// bdeg_ctrl
// Sequencer that walks one sample through the debounce and window steps,
// the divide and burst steps when a burst is due, and the publish step of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bdeg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bdeg_pkg::dp_status_type status,
   output bdeg_pkg::ctl_cmd_type       cmd
);
   import bdeg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEBOUNCE,
      ST_WINDOW,
      ST_DIVIDE,
      ST_BURST,
      ST_PUBLISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DEBOUNCE;
            end
         end
         ST_DEBOUNCE: begin
            cmd.debounce = 1'b1;
            state_in     = ST_WINDOW;
         end
         ST_WINDOW: begin
            cmd.window = 1'b1;
            state_in   = status.burst_check ? ST_DIVIDE : ST_PUBLISH;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_BURST;
            end
         end
         ST_BURST: begin
            cmd.burst = 1'b1;
            state_in  = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            cmd.publish = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DEBOUNCE))
      else $error("Accepted beat did not start the debounce step.");

   a_div_ends_in_burst: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> cmd.burst)
      else $error("Division did not hand over to the burst step.");

   a_publish_once: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> req_ready)
      else $error("Block did not return to idle after publishing.");

endmodule

`default_nettype wire

// File: hdl/bdeg_dpath.sv
// ----------------------------------------------------------------------------
// bdeg_dpath
// Configuration registers, debounce and click state, a radix-2 restoring
// divider for the burst count, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdeg_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bdeg_pkg::ctl_cmd_type                 cmd,
   output bdeg_pkg::dp_status_type                    status,
   input  wire bdeg_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output bdeg_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_write_en,
   input  wire logic [bdeg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [bdeg_pkg::CFG_W-1:0]            csr_wdata
);
   import bdeg_pkg::*;

   localparam int DIV_CNT_W = $clog2(TIME_W);

   logic               switch_mode_ff, switch_mode_in;
   logic               default_high_ff, default_high_in;
   logic [CFG_W-1:0]   debounce_ms_ff, debounce_ms_in;
   logic [CFG_W-1:0]   repeat_ms_ff, repeat_ms_in;
   logic [CFG_W-1:0]   long_press_ms_ff, long_press_ms_in;
   logic [CFG_W-1:0]   burst_delay_ms_ff, burst_delay_ms_in;
   logic [CFG_W-1:0]   burst_interval_ms_ff, burst_interval_ms_in;

   logic               stable_level_ff, stable_level_in;
   logic               last_raw_level_ff, last_raw_level_in;
   logic [TIME_W-1:0]  last_edge_time_ff, last_edge_time_in;
   logic [TIME_W-1:0]  press_start_time_ff, press_start_time_in;
   logic [TIME_W-1:0]  press_length_ff, press_length_in;
   logic [COUNT_W-1:0] press_count_ff, press_count_in;
   logic               release_pending_ff, release_pending_in;
   logic               count_restart_ff, count_restart_in;
   logic               long_reported_ff, long_reported_in;
   logic [TIME_W-1:0]  bursts_done_ff, bursts_done_in;
   logic [EVENT_W-1:0] event_ff, event_in;
   logic               rsp_valid_ff, rsp_valid_in;

   req_type            sample_ff, sample_in;
   rsp_type            rsp_ff, rsp_in;
   logic [TIME_W-1:0]  held_ff, held_in;
   logic [TIME_W-1:0]  quo_ff, quo_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [TIME_W-1:0]  edge_age;
   logic [TIME_W-1:0]  held;
   logic               settled;
   logic               release_fire;
   logic               hold_active;
   logic               long_fire;
   logic [CFG_W-1:0]   divisor;
   logic [CFG_W:0]     rem_shift;
   logic [CFG_W:0]     rem_diff;
   logic               quo_bit;

   assign edge_age = sample_ff.now_ms - last_edge_time_ff;
   assign settled  = edge_age > {{(TIME_W-CFG_W){1'b0}}, debounce_ms_ff};
   assign held     = sample_ff.now_ms - press_start_time_ff;

   assign release_fire = release_pending_ff &&
                         (held > {{(TIME_W-CFG_W){1'b0}}, repeat_ms_ff});
   assign hold_active  = !switch_mode_ff && !(release_pending_ff && !release_fire) &&
                         (stable_level_ff != default_high_ff);
   assign long_fire    = hold_active && (!long_reported_ff || release_fire) &&
                         (held > {{(TIME_W-CFG_W){1'b0}}, long_press_ms_ff});

   assign divisor   = (burst_interval_ms_ff == '0) ? MIN_INTERVAL : burst_interval_ms_ff;
   assign rem_shift = {rem_ff, quo_ff[TIME_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign quo_bit   = (rem_shift >= {1'b0, divisor});

   assign status.burst_check = hold_active && !long_fire &&
                               (held > {{(TIME_W-CFG_W){1'b0}}, burst_delay_ms_ff});
   assign status.div_last    = &div_cnt_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      switch_mode_in       = switch_mode_ff;
      default_high_in      = default_high_ff;
      debounce_ms_in       = debounce_ms_ff;
      repeat_ms_in         = repeat_ms_ff;
      long_press_ms_in     = long_press_ms_ff;
      burst_delay_ms_in    = burst_delay_ms_ff;
      burst_interval_ms_in = burst_interval_ms_ff;
      stable_level_in      = stable_level_ff;
      last_raw_level_in    = last_raw_level_ff;
      last_edge_time_in    = last_edge_time_ff;
      press_start_time_in  = press_start_time_ff;
      press_length_in      = press_length_ff;
      press_count_in       = press_count_ff;
      release_pending_in   = release_pending_ff;
      count_restart_in     = count_restart_ff;
      long_reported_in     = long_reported_ff;
      bursts_done_in       = bursts_done_ff;
      event_in             = event_ff;
      rsp_valid_in         = rsp_valid_ff;
      sample_in            = sample_ff;
      rsp_in               = rsp_ff;
      held_in              = held_ff;
      quo_in               = quo_ff;
      rem_in               = rem_ff;
      div_cnt_in           = div_cnt_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SWITCH_MODE: begin
               switch_mode_in = csr_wdata[0];
            end
            CSR_DEFAULT_HIGH: begin
               default_high_in   = csr_wdata[0];
               stable_level_in   = csr_wdata[0];
               last_raw_level_in = csr_wdata[0];
            end
            CSR_DEBOUNCE_MS: begin
               debounce_ms_in = csr_wdata;
            end
            CSR_REPEAT_MS: begin
               repeat_ms_in = csr_wdata;
            end
            CSR_LONG_PRESS_MS: begin
               long_press_ms_in = csr_wdata;
            end
            CSR_BURST_DELAY_MS: begin
               burst_delay_ms_in = csr_wdata;
            end
            CSR_BURST_INTERVAL_MS: begin
               burst_interval_ms_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         sample_in = req_data;
      end

      if (cmd.debounce) begin
         event_in = EV_NONE;
         if (sample_ff.level != stable_level_ff) begin
            if (sample_ff.level != last_raw_level_ff) begin
               last_edge_time_in = sample_ff.now_ms;
               last_raw_level_in = sample_ff.level;
            end else if (settled) begin
               stable_level_in = !stable_level_ff;
               if (switch_mode_ff) begin
                  event_in = EV_CHANGED;
               end else if (!stable_level_ff == default_high_ff) begin
                  press_length_in    = held;
                  release_pending_in = 1'b1;
               end else begin
                  event_in            = EV_PRESSED;
                  press_start_time_in = sample_ff.now_ms;
                  press_length_in     = '0;
                  if (count_restart_ff) begin
                     press_count_in   = COUNT_ONE;
                     count_restart_in = 1'b0;
                  end else if (press_count_ff != COUNT_MAX) begin
                     press_count_in = press_count_ff + COUNT_ONE;
                  end
                  release_pending_in = 1'b0;
               end
            end
         end else if ((sample_ff.level != last_raw_level_ff) && settled) begin
            last_raw_level_in = sample_ff.level;
         end
      end

      if (cmd.window) begin
         if (release_fire) begin
            release_pending_in = 1'b0;
            count_restart_in   = 1'b1;
            event_in           = EV_RELEASED;
            long_reported_in   = 1'b0;
            bursts_done_in     = '0;
         end
         if (long_fire) begin
            event_in         = EV_LONG;
            press_length_in  = held;
            long_reported_in = 1'b1;
         end
         if (status.burst_check) begin
            held_in    = held;
            quo_in     = held;
            rem_in     = '0;
            div_cnt_in = '0;
         end
      end

      if (cmd.div_step) begin
         rem_in     = quo_bit ? rem_diff[CFG_W-1:0] : rem_shift[CFG_W-1:0];
         quo_in     = {quo_ff[TIME_W-2:0], quo_bit};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.burst && (quo_ff > bursts_done_ff)) begin
         event_in        = EV_BURST;
         bursts_done_in  = quo_ff;
         press_length_in = held_ff;
      end

      if (cmd.publish) begin
         rsp_in.event_code  = event_ff;
         rsp_in.click_count = press_count_ff;
         rsp_in.hold_length = press_length_ff;
         rsp_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_mode_ff       <= 1'b0;
         default_high_ff      <= 1'b0;
         debounce_ms_ff       <= DEBOUNCE_MS_RESET;
         repeat_ms_ff         <= REPEAT_MS_RESET;
         long_press_ms_ff     <= LONG_PRESS_MS_RESET;
         burst_delay_ms_ff    <= BURST_DELAY_MS_RESET;
         burst_interval_ms_ff <= BURST_INTERVAL_MS_RESET;
         stable_level_ff      <= 1'b0;
         last_raw_level_ff    <= 1'b0;
         last_edge_time_ff    <= '0;
         press_start_time_ff  <= '0;
         press_length_ff      <= '0;
         press_count_ff       <= '0;
         release_pending_ff   <= 1'b0;
         count_restart_ff     <= 1'b1;
         long_reported_ff     <= 1'b0;
         bursts_done_ff       <= '0;
         event_ff             <= EV_NONE;
         rsp_valid_ff         <= 1'b0;
         div_cnt_ff           <= '0;
      end else begin
         switch_mode_ff       <= switch_mode_in;
         default_high_ff      <= default_high_in;
         debounce_ms_ff       <= debounce_ms_in;
         repeat_ms_ff         <= repeat_ms_in;
         long_press_ms_ff     <= long_press_ms_in;
         burst_delay_ms_ff    <= burst_delay_ms_in;
         burst_interval_ms_ff <= burst_interval_ms_in;
         stable_level_ff      <= stable_level_in;
         last_raw_level_ff    <= last_raw_level_in;
         last_edge_time_ff    <= last_edge_time_in;
         press_start_time_ff  <= press_start_time_in;
         press_length_ff      <= press_length_in;
         press_count_ff       <= press_count_in;
         release_pending_ff   <= release_pending_in;
         count_restart_ff     <= count_restart_in;
         long_reported_ff     <= long_reported_in;
         bursts_done_ff       <= bursts_done_in;
         event_ff             <= event_in;
         rsp_valid_ff         <= rsp_valid_in;
         div_cnt_ff           <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      rsp_ff    <= rsp_in;
      held_ff   <= held_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("Published beat did not raise the result valid.");

   a_press_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_code == EV_PRESSED)) |-> (rsp_ff.click_count != '0))
      else $error("Pressed event carries a zero click count.");

   a_div_wraps: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> (div_cnt_ff == '0))
      else $error("Divider step counter did not wrap after the last step.");

endmodule

`default_nettype wire

// File: hdl/button_debounce_event_generator_top.sv
// ----------------------------------------------------------------------------
// button_debounce_event_generator_top
// Button debouncer with click counting, long-press and burst events.
// ----------------------------------------------------------------------------
// Each accepted sample yields exactly one result beat. A sample passes the
// debounce, window and publish steps on its way to the result register, plus
// divide and burst steps when the button is held past the burst delay without
// a long-press event; the burst count runs through a one-bit-per-cycle 32-step
// restoring divider. The next sample is taken once the current result has moved
// into the output register, where a waiting result stalls the next publish.
`default_nettype none

module button_debounce_event_generator_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire bdeg_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output bdeg_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write_en,
   input  wire logic [bdeg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bdeg_pkg::CFG_W-1:0]      csr_wdata
);
   import bdeg_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   bdeg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bdeg_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

`default_nettype wire
